>>> rtl/core/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define AST_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check across reset failed");

`endif

>>> rtl/core/lfc_pkg.sv
package lfc_pkg;

    // field widths
    localparam int SampleW  = 20;
    localparam int TapW     = 16;
    localparam int PosW     = 10;
    localparam int KwW      = 3;
    localparam int CntW     = 3;
    localparam int NumTaps  = 7;

    // configuration port
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // arithmetic: Q12.8 x Q2.14 products, sum of up to seven
    localparam int ProdW     = SampleW + TapW;
    localparam int AccW      = ProdW + 3;
    localparam int FracShift = 14;
    localparam int RoundBias = 8192;
    localparam int OutMax    = 524287;
    localparam int OutMin    = -524288;

    // parameter defaults
    localparam int MaxTapsDef = 7;
    localparam int MaxLineDef = 1024;
    localparam int KwReset    = 7;

    typedef enum logic [CfgIdxW-1:0] {
        CfgKernelWidth = 3'd0,
        CfgTap0        = 3'd1,
        CfgTap1        = 3'd2,
        CfgTap2        = 3'd3,
        CfgTap3        = 3'd4,
        CfgTap4        = 3'd5,
        CfgTap5        = 3'd6,
        CfgTap6        = 3'd7
    } t_cfg_idx;

endpackage

>>> rtl/core/lfc_if.sv
// Sample stream into the filter.
interface lfc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lfc_pkg::SampleW-1:0]  sample;
    logic                                end_of_line;

    modport source (output valid, sample, end_of_line, input ready);
    modport sink   (input valid, sample, end_of_line, output ready);
endinterface

// Filtered result stream.
interface lfc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lfc_pkg::SampleW-1:0]  filtered;
    logic        [lfc_pkg::PosW-1:0]     position;
    logic                                line_done;

    modport source (output valid, filtered, position, line_done, input ready);
    modport sink   (input valid, filtered, position, line_done, output ready);
endinterface

>>> rtl/core/line_fir_convolver_zero_border.sv
// Line FIR convolver with zero border. Takes one Q12.8 sample per cycle and
// returns a true convolution with up to seven Q2.14 taps, rounded half up and
// saturated to Q12.8. Positions within width/2 of either line end are zero,
// interior results trail their input by radius samples, and the sample flagged
// end_of_line releases the tail of the line as a burst of up to radius+1 words
// (the whole line when it is no longer than radius), the last one carrying
// line_done. Every word carries its position in the line.
// Rate: one sample per cycle for as long as each sample yields at most one
// word and the output is taken; an end-of-line sample holds the output for
// its whole burst, and once the three stages ahead of the output are full the
// input is held off until the burst drains. The four register stages
// (capture, multiply, sum, round and emit) carry the word a sample completes
// to the output. The user must write configuration only while the block is
// idle; the block itself does not enforce this.
module line_fir_convolver_zero_border #(
    parameter int MAX_TAPS = lfc_pkg::MaxTapsDef,
    parameter int MAX_LINE = lfc_pkg::MaxLineDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lfc_in_if.sink                        i_samp,
    lfc_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [lfc_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [lfc_pkg::CfgDataW-1:0]  i_cfg_data
);

    localparam int SampleW = lfc_pkg::SampleW;
    localparam int TapW    = lfc_pkg::TapW;
    localparam int PosW    = lfc_pkg::PosW;
    localparam int KwW     = lfc_pkg::KwW;
    localparam int CntW    = lfc_pkg::CntW;
    localparam int ProdW   = lfc_pkg::ProdW;
    localparam int AccW    = lfc_pkg::AccW;
    localparam int FracSh  = lfc_pkg::FracShift;
    localparam int QW      = AccW - FracSh;
    localparam int NumTaps = lfc_pkg::NumTaps;
    localparam int TapIdxW = $clog2(NumTaps);
    localparam int IdxW    = $clog2(MAX_LINE);
    localparam int HistN   = MAX_TAPS + 1;
    localparam int HistW   = $clog2(HistN);

    localparam logic [IdxW-1:0]       LastIdx = IdxW'(MAX_LINE - 1);
    localparam logic [KwW-1:0]        KwMax   = KwW'(MAX_TAPS);
    localparam logic signed [QW-1:0]  QMax    = QW'(lfc_pkg::OutMax);
    localparam logic signed [QW-1:0]  QMin    = QW'(lfc_pkg::OutMin);
    localparam logic [AccW-1:0]       Bias    = AccW'(lfc_pkg::RoundBias);

    // round half up to Q12.8, then clamp
    function automatic logic signed [SampleW-1:0] round_sat(
        input logic signed [AccW-1:0] acc
    );
        logic signed [AccW-1:0] biased;
        logic signed [QW-1:0]   q;
        biased = acc + $signed(Bias);
        q      = biased[AccW-1:FracSh];
        if (q > QMax) begin
            q = QMax;
        end else if (q < QMin) begin
            q = QMin;
        end
        return SampleW'(q);
    endfunction

    // configuration registers
    logic        [KwW-1:0]   r_kw;
    logic signed [TapW-1:0]  r_tap [NumTaps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw <= KwW'(lfc_pkg::KwReset);
            for (int t = 0; t < NumTaps; t++) begin
                r_tap[t] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == lfc_pkg::CfgKernelWidth) begin
                r_kw <= i_cfg_data[KwW-1:0];
            end else begin
                r_tap[TapIdxW'(i_cfg_idx - lfc_pkg::CfgTap0)] <= $signed(i_cfg_data);
            end
        end
    end

    // effective width and radius
    logic [KwW-1:0]   kw_eff;
    logic [KwW-2:0]   rad;
    logic [HistW-1:0] two_rad;

    assign kw_eff  = (r_kw > KwMax) ? KwMax : r_kw;
    assign rad     = kw_eff[KwW-1:1];
    assign two_rad = HistW'({rad, 1'b0});

    // pipeline handshake
    logic r_v1, r_v2, r_v3;
    logic [CntW-1:0] r_cnt;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_fire, out_fire;

    assign rdy4     = (r_cnt == '0) || ((r_cnt == CntW'(1)) && o_res.ready);
    assign rdy3     = !r_v3 || rdy4;
    assign rdy2     = !r_v2 || rdy3;
    assign rdy1     = !r_v1 || rdy2;
    assign in_fire  = i_samp.valid && rdy1;
    assign out_fire = (r_cnt != '0) && o_res.ready;
    assign i_samp.ready = rdy1;

    // line state: sample history and index of the next sample
    logic signed [SampleW-1:0] r_win [MAX_TAPS];
    logic        [IdxW-1:0]    r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (in_fire) begin
            if (i_samp.end_of_line) begin
                r_idx <= '0;
            end else if (r_idx != LastIdx) begin
                r_idx <= r_idx + IdxW'(1);
            end
        end
    end

    // stale history from a previous line is never used: a result needs 2r new samples
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_win[0] <= i_samp.sample;
            for (int k = 1; k < MAX_TAPS; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // stage 1: capture the sample with its history
    logic signed [SampleW-1:0] r_hist1 [HistN];
    logic        [IdxW-1:0]    r_idx1;
    logic                      r_eol1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hist1[0] <= i_samp.sample;
            for (int k = 1; k < HistN; k++) begin
                r_hist1[k] <= r_win[k-1];
            end
            r_idx1 <= r_idx;
            r_eol1 <= i_samp.end_of_line;
        end
    end

    // stage 1 logic: one multiplier per lane, kernel applied reversed
    logic signed [ProdW-1:0] prod [MAX_TAPS];

    always_comb begin
        logic [HistW-1:0]   hidx;
        logic [TapIdxW-1:0] tidx;
        for (int k = 0; k < MAX_TAPS; k++) begin
            hidx = two_rad - HistW'(k);
            tidx = TapIdxW'(kw_eff - KwW'(1) - KwW'(k));
            if (KwW'(k) < kw_eff) begin
                prod[k] = r_hist1[hidx] * r_tap[tidx];
            end else begin
                prod[k] = '0;
            end
        end
    end

    // stage 1 logic: which positions this sample releases
    logic            n_useval;
    logic [CntW-1:0] n_cnt;
    logic [IdxW-1:0] n_start;
    logic            past_rad;

    always_comb begin
        past_rad = r_idx1 >= IdxW'(rad);
        n_useval = r_idx1 >= IdxW'(two_rad);
        n_start  = past_rad ? (r_idx1 - IdxW'(rad)) : '0;
        if (r_eol1) begin
            n_cnt = past_rad ? (CntW'(rad) + CntW'(1)) : (CntW'(r_idx1) + CntW'(1));
        end else begin
            n_cnt = past_rad ? CntW'(1) : '0;
        end
    end

    // stage 2: products
    logic signed [ProdW-1:0] r_prod2 [MAX_TAPS];
    logic        [CntW-1:0]  r_cnt2;
    logic        [IdxW-1:0]  r_start2;
    logic                    r_eol2, r_useval2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_prod2[k] <= prod[k];
            end
            r_cnt2    <= n_cnt;
            r_start2  <= n_start;
            r_eol2    <= r_eol1;
            r_useval2 <= n_useval;
        end
    end

    // stage 3: sum of products
    logic signed [AccW-1:0] sum;
    logic signed [AccW-1:0] r_acc3;
    logic        [CntW-1:0] r_cnt3;
    logic        [IdxW-1:0] r_start3;
    logic                   r_eol3, r_useval3;

    always_comb begin
        sum = '0;
        for (int k = 0; k < MAX_TAPS; k++) begin
            sum = sum + AccW'(r_prod2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_acc3    <= sum;
            r_cnt3    <= r_cnt2;
            r_start3  <= r_start2;
            r_eol3    <= r_eol2;
            r_useval3 <= r_useval2;
        end
    end

    // stage 4: round, then emit the words one per cycle while the output is ready
    logic signed [SampleW-1:0] r_val;
    logic        [IdxW-1:0]    r_pos;
    logic                      r_first, r_eol, r_useval;
    logic                      load;

    assign load = r_v3 && rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= r_cnt3;
        end else if (out_fire) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val    <= round_sat(r_acc3);
            r_pos    <= r_start3;
            r_first  <= 1'b1;
            r_eol    <= r_eol3;
            r_useval <= r_useval3;
        end else if (out_fire) begin
            r_pos    <= r_pos + IdxW'(1);
            r_first  <= 1'b0;
        end
    end

    // only the first word of a group can hold a computed value
    assign o_res.valid     = r_cnt != '0;
    assign o_res.filtered  = (r_first && r_useval) ? r_val : '0;
    assign o_res.position  = PosW'(r_pos);
    assign o_res.line_done = r_eol && (r_cnt == CntW'(1));

endmodule

>>> rtl/core/lfc_checker.sv
`include "assert_macros.svh"

module lfc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [lfc_pkg::SampleW-1:0]   i_out_filtered,
    input logic [lfc_pkg::PosW-1:0]      i_out_position,
    input logic                          i_out_line_done
);

    // whole contents of the offered word
    logic [lfc_pkg::SampleW+lfc_pkg::PosW:0] out_word;

    assign out_word = {i_out_filtered, i_out_position, i_out_line_done};

    // a stalled word stays offered
    `AST_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // and keeps its contents
    `AST_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(out_word))

    // reset empties the pipe: nothing offered, input open
    `AST_NXT_ALL(a_rst_empty, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

    // input is only held off behind a pending output word
    `AST_IMP(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid)

endmodule

bind line_fir_convolver_zero_border lfc_checker u_lfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_samp.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_filtered  (o_res.filtered),
    .i_out_position  (o_res.position),
    .i_out_line_done (o_res.line_done)
);
